[hdl/pcme_pkg.sv]
// ----------------------------------------------------------------------------
// pcme_pkg
// Shared widths, codes and types for the pointwise convolution MAC engine.
// ----------------------------------------------------------------------------
package pcme_pkg;

  localparam int unsigned DATA_W       = 16;
  localparam int unsigned IN_CH_MAX    = 1024;
  localparam int unsigned ADDR_W       = $clog2(IN_CH_MAX);
  localparam int unsigned ACC_W        = 41;
  localparam int unsigned PROD_W       = 2 * DATA_W;
  localparam int unsigned CHAN_W       = 4;
  localparam int unsigned USED_W       = 5;
  localparam int unsigned OUT_TILE_DEF = 16;
  localparam int unsigned USED_RESET   = 16;

  // item kinds
  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_ACT    = 1'b1;

  // activation tag travelling down the mac pipeline
  typedef struct packed {
    logic act;
    logic pend;
  } tag_t;

  // snapshot of the accumulators at the end of a pixel
  typedef struct packed {
    logic              load;
    logic [USED_W-1:0] used;
  } snap_t;

endpackage

[hdl/pcme_weight_mem.sv]
// ----------------------------------------------------------------------------
// pcme_weight_mem
// Weight store: one row per input channel, one lane per output channel.
// Lane write, registered full-row read.
// ----------------------------------------------------------------------------
module pcme_weight_mem #(
  parameter int unsigned OUT_TILE = pcme_pkg::OUT_TILE_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [pcme_pkg::CHAN_W-1:0]             lane_i,
  input  logic [pcme_pkg::ADDR_W-1:0]             addr_i,
  input  logic [pcme_pkg::DATA_W-1:0]             wdata_i,
  input  logic                                    re_i,
  output logic [OUT_TILE*pcme_pkg::DATA_W-1:0]    rdata_o
);

  localparam int unsigned ROW_W = OUT_TILE * pcme_pkg::DATA_W;

  logic [ROW_W-1:0] mem_q [pcme_pkg::IN_CH_MAX];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int l = 0; l < OUT_TILE; l++) begin
        if (lane_i == pcme_pkg::CHAN_W'(l)) begin
          mem_q[addr_i][l*pcme_pkg::DATA_W +: pcme_pkg::DATA_W] <= wdata_i;
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pcme_mac_array.sv]
// ----------------------------------------------------------------------------
// pcme_mac_array
// Per-lane multiply stage and accumulate stage over the weight row read
// from the weight store. Produces the end-of-pixel snapshot.
// ----------------------------------------------------------------------------
module pcme_mac_array #(
  parameter int unsigned OUT_TILE = pcme_pkg::OUT_TILE_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pcme_pkg::tag_t                        tag_i,
  input  logic [pcme_pkg::DATA_W-1:0]           act_i,
  input  logic [pcme_pkg::USED_W-1:0]           used_i,
  input  logic [OUT_TILE*pcme_pkg::DATA_W-1:0]  rdata_i,
  output pcme_pkg::snap_t                       snap_o,
  output logic [pcme_pkg::ACC_W-1:0]            snap_sum_o [OUT_TILE],
  output logic                                  pend_inflight_o
);

  pcme_pkg::tag_t                           s1_q, s2_q;
  logic signed [pcme_pkg::DATA_W-1:0]       act_q;
  logic signed [pcme_pkg::PROD_W-1:0]       prod_d [OUT_TILE];
  logic signed [pcme_pkg::PROD_W-1:0]       prod_q [OUT_TILE];
  logic        [pcme_pkg::ACC_W-1:0]        acc_q  [OUT_TILE];
  logic        [pcme_pkg::ACC_W-1:0]        sum_d  [OUT_TILE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= tag_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.act) begin
      act_q <= act_i;
    end
  end

  // multiply stage: the weight row arrives in the cycle after the read
  always_comb begin
    for (int l = 0; l < OUT_TILE; l++) begin
      prod_d[l] = act_q * $signed(rdata_i[l*pcme_pkg::DATA_W +: pcme_pkg::DATA_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.act) begin
      for (int l = 0; l < OUT_TILE; l++) begin
        prod_q[l] <= prod_d[l];
      end
    end
  end

  // accumulate stage, lanes beyond the used count keep their value; a pixel end clears every lane
  always_comb begin
    for (int l = 0; l < OUT_TILE; l++) begin
      sum_d[l] = acc_q[l] + ((pcme_pkg::USED_W'(l) < used_i) ?
                             pcme_pkg::ACC_W'(prod_q[l]) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < OUT_TILE; l++) begin
        acc_q[l] <= '0;
      end
    end else if (s2_q.act) begin
      for (int l = 0; l < OUT_TILE; l++) begin
        acc_q[l] <= s2_q.pend ? '0 : sum_d[l];
      end
    end
  end

  assign snap_sum_o      = sum_d;
  assign snap_o.load     = s2_q.act & s2_q.pend;
  assign snap_o.used     = used_i;
  assign pend_inflight_o = (s1_q.act & s1_q.pend) | (s2_q.act & s2_q.pend);

  a_one_pend_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((s1_q.act && s1_q.pend) && (s2_q.act && s2_q.pend)))
    else $error("two pixel ends in the mac pipeline");

endmodule

[hdl/pcme_drain.sv]
// ----------------------------------------------------------------------------
// pcme_drain
// Result buffer: takes the end-of-pixel snapshot and shifts the sums out
// one item per cycle while the output is not stalled, marking the last used channel.
// ----------------------------------------------------------------------------
module pcme_drain #(
  parameter int unsigned OUT_TILE = pcme_pkg::OUT_TILE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcme_pkg::snap_t                  snap_i,
  input  logic [pcme_pkg::ACC_W-1:0]       snap_sum_i [OUT_TILE],
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pcme_pkg::CHAN_W-1:0]      channel_o,
  output logic [pcme_pkg::ACC_W-1:0]       sum_o,
  output logic                             final_res_o
);

  logic [pcme_pkg::ACC_W-1:0]  buf_q [OUT_TILE];
  logic                        busy_q;
  logic [pcme_pkg::CHAN_W-1:0] cnt_q, last_q;
  logic                        take;
  logic                        is_last;

  assign take    = busy_q & ~out_stall_i;
  assign is_last = (cnt_q == last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      last_q <= '0;
    end else if (snap_i.load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      last_q <= pcme_pkg::CHAN_W'(snap_i.used - pcme_pkg::USED_W'(1));
    end else if (take) begin
      cnt_q <= cnt_q + pcme_pkg::CHAN_W'(1);
      if (is_last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_i.load) begin
      buf_q <= snap_sum_i;
    end else if (take) begin
      for (int l = 0; l < OUT_TILE - 1; l++) begin
        buf_q[l] <= buf_q[l+1];
      end
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = busy_q;
  assign channel_o   = cnt_q;
  assign sum_o       = buf_q[0];
  assign final_res_o = is_last;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_i.load |-> !busy_q)
    else $error("snapshot while results still draining");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !out_stall_i && is_last && !snap_i.load) |=> !busy_q)
    else $error("drain did not end after last item");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= last_q))
    else $error("drain count past last channel");

endmodule

[hdl/pointwise_conv_mac_engine_top.sv]
// ----------------------------------------------------------------------------
// pointwise_conv_mac_engine_top
// 1x1 convolution engine: weight store, parallel per-channel MAC lanes and a
// result buffer that drains the sums of each pixel.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; a pixel-end activation waits while an earlier
//   pixel end is in the mac pipeline or its results are still draining
// results: a pixel-end activation passes the weight read and product registers
//   to the result buffer; one result per cycle per used channel unless stalled
// reset: clears accumulators, drain state and channel count (16); result buffer
//   and weight store are not cleared and hold garbage until written
// ----------------------------------------------------------------------------
module pointwise_conv_mac_engine_top #(
  parameter int unsigned OUT_TILE = pcme_pkg::OUT_TILE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [pcme_pkg::CHAN_W-1:0]       out_index_i,
  input  logic [pcme_pkg::ADDR_W-1:0]       in_index_i,
  input  logic signed [pcme_pkg::DATA_W-1:0] value_i,
  input  logic                              pixel_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pcme_pkg::CHAN_W-1:0]       channel_o,
  output logic signed [pcme_pkg::ACC_W-1:0] sum_o,
  output logic                              final_res_o,
  input  logic                              cfg_we_i,
  input  logic [pcme_pkg::USED_W-1:0]       cfg_wdata_i
);

  localparam int unsigned OIDX_N = 2 ** pcme_pkg::CHAN_W;

  logic [pcme_pkg::USED_W-1:0]           used_cfg_q;
  logic [pcme_pkg::USED_W-1:0]           used;
  logic                                  accept;
  logic                                  mem_we, mem_re;
  logic [pcme_pkg::CHAN_W-1:0]           oidx_tbl [OIDX_N];
  logic [OUT_TILE*pcme_pkg::DATA_W-1:0]  rdata;
  pcme_pkg::tag_t                        tag;
  pcme_pkg::snap_t                       snap;
  logic [pcme_pkg::ACC_W-1:0]            snap_sum [OUT_TILE];
  logic                                  pend_inflight;
  logic                                  drain_busy;
  logic [pcme_pkg::ACC_W-1:0]            sum_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_cfg_q <= pcme_pkg::USED_W'(pcme_pkg::USED_RESET);
    end else if (cfg_we_i) begin
      used_cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    priority if (used_cfg_q == '0) begin
      used = pcme_pkg::USED_W'(1);
    end else if (used_cfg_q > pcme_pkg::USED_W'(OUT_TILE)) begin
      used = pcme_pkg::USED_W'(OUT_TILE);
    end else begin
      used = used_cfg_q;
    end
  end

  // out_index wraps onto the tile
  for (genvar gi = 0; gi < OIDX_N; gi++) begin : g_oidx
    assign oidx_tbl[gi] = pcme_pkg::CHAN_W'(gi % OUT_TILE);
  end

  // a pixel end holds off while an earlier one is in the mac pipeline or draining
  assign in_stall_o = in_valid_i & (kind_i == pcme_pkg::KIND_ACT) & pixel_end_i &
                      (pend_inflight | drain_busy);
  assign accept     = in_valid_i & ~in_stall_o;
  assign mem_we     = accept & (kind_i == pcme_pkg::KIND_WEIGHT);
  assign mem_re     = accept & (kind_i == pcme_pkg::KIND_ACT);

  assign tag.act  = mem_re;
  assign tag.pend = pixel_end_i;

  pcme_weight_mem #(
    .OUT_TILE (OUT_TILE)
  ) u_wmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .lane_i  (oidx_tbl[out_index_i]),
    .addr_i  (in_index_i),
    .wdata_i (value_i),
    .re_i    (mem_re),
    .rdata_o (rdata)
  );

  pcme_mac_array #(
    .OUT_TILE (OUT_TILE)
  ) u_mac (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tag_i           (tag),
    .act_i           (value_i),
    .used_i          (used),
    .rdata_i         (rdata),
    .snap_o          (snap),
    .snap_sum_o      (snap_sum),
    .pend_inflight_o (pend_inflight)
  );

  pcme_drain #(
    .OUT_TILE (OUT_TILE)
  ) u_drain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_i      (snap),
    .snap_sum_i  (snap_sum),
    .busy_o      (drain_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .channel_o   (channel_o),
    .sum_o       (sum_raw),
    .final_res_o (final_res_o)
  );

  assign sum_o = $signed(sum_raw);

endmodule
